[rtl/core/assert_macros.svh]
// assertion helpers shared by the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// plain property, checked on every clock edge outside reset
`define CORE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("core assertion failed");
// antecedent implies consequent in the same cycle
`define CORE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("core assertion failed");
// antecedent implies consequent in the next cycle
`define CORE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("core assertion failed");
`else
`define CORE_ASSERT(lbl, clk, rst, prop)
`define CORE_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define CORE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/core/s2dec_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package s2dec_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int NDIGITS     = 10;
  localparam int BCD_W       = NDIGITS * DIGIT_W;
  localparam int POS_W       = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  typedef logic [NDIGITS-1:0][DIGIT_W-1:0] bcd_t;

  // one converted number waiting for output
  typedef struct packed {
    logic             neg;
    logic [POS_W-1:0] ndig;
    bcd_t             bcd;
  } conv_item_t;

endpackage
`default_nettype wire

[rtl/core/s2dec_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module s2dec_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic signed [s2dec_pkg::VALUE_W-1:0] s_tdata,
  output logic                                     push_valid,
  input  wire logic                                push_ready,
  output s2dec_pkg::conv_item_t                    push_item
);

  localparam int VW    = s2dec_pkg::VALUE_W;
  localparam int BW    = s2dec_pkg::BCD_W;
  localparam int DW    = s2dec_pkg::DIGIT_W;
  localparam int ND    = s2dec_pkg::NDIGITS;
  localparam int CNT_W = $clog2(VW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VW - 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t         state;
  logic [VW-1:0]        sh;
  s2dec_pkg::bcd_t      bcd;
  logic                 neg;
  logic [CNT_W-1:0]     cnt;
  logic [BW-1:0]        bcd_adj;
  logic [BW-1:0]        bcd_next;
  logic [VW-1:0]        din;
  logic [s2dec_pkg::POS_W-1:0] ndig;

  assign din = $unsigned(s_tdata);

  // double dabble: add 3 to every digit of 5 or more, then shift one bit in
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      if (bcd[i] >= DW'(5)) begin
        bcd_adj[i*DW +: DW] = bcd[i] + DW'(3);
      end else begin
        bcd_adj[i*DW +: DW] = bcd[i];
      end
    end
    bcd_next = {bcd_adj[BW-2:0], sh[VW-1]};
  end

  // count of significant digits, at least one
  always_comb begin
    ndig = s2dec_pkg::POS_W'(1);
    for (int i = 0; i < ND; i++) begin
      if (bcd[i] != '0) ndig = s2dec_pkg::POS_W'(i + 1);
    end
  end

  assign s_tready       = (state == F_IDLE);
  assign push_valid     = (state == F_PUSH);
  assign push_item.neg  = neg;
  assign push_item.ndig = ndig;
  assign push_item.bcd  = bcd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (s_tvalid) begin
            neg   <= din[VW-1];
            sh    <= din[VW-1] ? (VW'(0) - din) : din;
            bcd   <= '0;
            cnt   <= '0;
            state <= F_CONV;
          end
        end
        F_CONV: begin
          bcd <= bcd_next;
          sh  <= {sh[VW-2:0], 1'b0};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) state <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) state <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/s2dec_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module s2dec_queue #(
  parameter int DEPTH = s2dec_pkg::QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push_valid,
  output logic                       push_ready,
  input  wire s2dec_pkg::conv_item_t push_item,
  output logic                       pop_valid,
  input  wire logic                  pop_ready,
  output s2dec_pkg::conv_item_t      pop_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  s2dec_pkg::conv_item_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (cnt != CNT_FULL);
  assign pop_valid  = (cnt != '0);
  assign pop_item   = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) entries[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push_fire) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      if (pop_fire)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      if (push_fire && !pop_fire) begin
        cnt <= cnt + CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  `CORE_ASSERT(a_cnt_bound, clk, rst, cnt <= CNT_FULL)
  `CORE_ASSERT_NEXT(a_cnt_up, clk, rst, push_fire && !pop_fire, cnt == $past(cnt) + CNT_W'(1))
  `CORE_ASSERT_NEXT(a_cnt_down, clk, rst, pop_fire && !push_fire, cnt == $past(cnt) - CNT_W'(1))

endmodule
`default_nettype wire

[rtl/core/s2dec_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module s2dec_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          pop_valid,
  output logic                               pop_ready,
  input  wire s2dec_pkg::conv_item_t         pop_item,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [s2dec_pkg::CHAR_W-1:0]       m_tdata,
  output logic                               m_tlast
);

  localparam int PW = s2dec_pkg::POS_W;
  localparam int CW = s2dec_pkg::CHAR_W;
  localparam int DW = s2dec_pkg::DIGIT_W;

  logic            busy;
  logic            neg_pend;
  logic [PW-1:0]   pos;
  s2dec_pkg::bcd_t bcd;
  logic            adv;
  logic [DW-1:0]   digit;

  assign pop_ready = !busy;
  assign adv       = !m_tvalid || m_tready;
  assign digit     = bcd[pos];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      neg_pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (busy && adv) begin
        m_tvalid <= 1'b1;
        if (neg_pend) begin
          m_tdata  <= s2dec_pkg::ASCII_MINUS;
          m_tlast  <= 1'b0;
          neg_pend <= 1'b0;
        end else begin
          m_tdata <= s2dec_pkg::ASCII_ZERO + CW'(digit);
          m_tlast <= (pos == '0);
          if (pos == '0) begin
            busy <= 1'b0;
          end else begin
            pos <= pos - PW'(1);
          end
        end
      end else begin
        if (m_tready) m_tvalid <= 1'b0;
        if (!busy && pop_valid) begin
          busy     <= 1'b1;
          neg_pend <= pop_item.neg;
          pos      <= pop_item.ndig - PW'(1);
          bcd      <= pop_item.bcd;
        end
      end
    end
  end

  `CORE_ASSERT_IMPL(a_minus_not_last, clk, rst,
    m_tvalid && (m_tdata == s2dec_pkg::ASCII_MINUS), !m_tlast)
  `CORE_ASSERT_IMPL(a_last_is_digit, clk, rst, m_tvalid && m_tlast,
    (m_tdata >= s2dec_pkg::ASCII_ZERO) && (m_tdata <= s2dec_pkg::ASCII_ZERO + CW'(9)))
  `CORE_ASSERT_IMPL(a_pos_range, clk, rst, busy, pos < PW'(s2dec_pkg::NDIGITS))

endmodule
`default_nettype wire

[rtl/core/signed_int_to_decimal_ascii_core.sv]
// Converts one signed 32-bit integer per input beat into its decimal ASCII
// text, sent as a run of output beats of one character each, most significant
// first: a leading '-' for negative numbers, no leading zeros, and a single
// '0' for zero, so a run is 1 to 11 beats with tlast on its final character.
// The front end takes the magnitude and turns it into ten BCD digits by shift
// and add-3, one magnitude bit per cycle; it takes no new number until it
// has accepted one, converted the whole magnitude and handed the result off,
// and this loop sets the sustained rate. A two-entry queue sits between the
// front end and the character emitter, which loads a number and then sends
// one character per cycle while the output is ready, so long runs and output
// stalls overlap with the next conversion.
`timescale 1ns / 1ps
`default_nettype none
module signed_int_to_decimal_ascii_core #(
  parameter int QUEUE_DEPTH = s2dec_pkg::QUEUE_DEPTH  // two or more
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input stream, one number per beat
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic signed [s2dec_pkg::VALUE_W-1:0] s_tdata,  // [31:0] value
  // output stream, one character per beat
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [s2dec_pkg::CHAR_W-1:0]              m_tdata,  // [7:0] text_char
  output logic                                      m_tlast   // last character
);

  // converted numbers, front end to queue
  logic                  fq_valid;
  logic                  fq_ready;
  s2dec_pkg::conv_item_t fq_item;

  // queue to character emitter
  logic                  qb_valid;
  logic                  qb_ready;
  s2dec_pkg::conv_item_t qb_item;

  // sign and magnitude, then binary to bcd
  s2dec_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item)
  );

  // decouples conversion from character output
  s2dec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  // walks the digits from the top, after an optional minus sign
  s2dec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_item  (qb_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire

[tb/s2dec_text_checker.sv]
`timescale 1ns / 1ps
module s2dec_text_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [s2dec_pkg::VALUE_W-1:0]  s_tdata,   // [31:0] value
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [s2dec_pkg::CHAR_W-1:0]   m_tdata,   // [7:0] text_char
  input  logic                           m_tlast,
  output int                             error_count,
  output int                             chars_pending,
  output int                             chars_checked
);
  import s2dec_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last;
  } char_beat_t;

  char_beat_t expected_text[$];
  int         errors = 0;
  int         checked = 0;

  // decimal text of one number, most significant character first
  function automatic void queue_decimal_text(input logic [VALUE_W-1:0] bits);
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  digits [NDIGITS];
    int                 nd;
    char_beat_t         beat;
    neg = bits[VALUE_W-1];
    mag = neg ? (~bits + 1'b1) : bits;
    nd  = 0;
    do begin
      digits[nd] = ASCII_ZERO + CHAR_W'(mag % 32'd10);
      nd++;
      mag = mag / 32'd10;
    end while (mag != 0 && nd < NDIGITS);
    if (neg) begin
      beat.text_char = ASCII_MINUS;
      beat.last      = 1'b0;
      expected_text.push_back(beat);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      beat.text_char = digits[i];
      beat.last      = (i == 0);
      expected_text.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    char_beat_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) queue_decimal_text(s_tdata);
      if (m_tvalid && m_tready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected beat: text_char %0d last %0b", m_tdata, m_tlast);
          errors++;
        end else begin
          want = expected_text.pop_front();
          checked++;
          if (m_tdata !== want.text_char) begin
            $error("text_char mismatch: expected %0d, actual %0d", want.text_char, m_tdata);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, m_tlast);
            errors++;
          end
        end
      end
    end
    error_count   <= errors;
    chars_pending <= expected_text.size();
    chars_checked <= checked;
  end

endmodule

[tb/tb_signed_int_to_decimal_ascii_core.sv]
`timescale 1ns / 1ps
module tb_signed_int_to_decimal_ascii_core;
  import s2dec_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic signed [VALUE_W-1:0] s_tdata;   // [31:0] value
  logic                      m_tvalid;
  logic                      m_tready;
  logic [CHAR_W-1:0]         m_tdata;   // [7:0] text_char
  logic                      m_tlast;   // last character

  int error_count;
  int chars_pending;
  int chars_checked;

  // pacing knobs, percent of cycles spent idle or stalled
  int send_idle;
  int recv_stall;
  // long receiver hold-off, requested by stimulus, counted by the receiver
  int hold_req;
  int hold_seen;
  int hold_left;
  int numbers_sent;

  signed_int_to_decimal_ascii_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  s2dec_text_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .error_count   (error_count),
    .chars_pending (chars_pending),
    .chars_checked (chars_checked)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit, well beyond the slowest legal run
  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    hold_seen = 0;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  // spread over all run lengths: raw words, small values, powers of ten
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p;
    int                 sel;
    p = 32'd1;
    repeat ($urandom_range(0, 9)) p = p * 32'd10;
    sel = $urandom_range(0, 3);
    case (sel)
      0: v = $urandom;
      1: v = $urandom_range(0, 999);
      2: v = p + $urandom_range(0, 2) - 32'd1;  // around a power of ten
      default: v = p + ($urandom % p);          // fixed digit count
    endcase
    if (sel != 0 && $urandom_range(0, 1)) v = ~v + 1'b1;
    return v;
  endfunction

  // one beat on the input, held until accepted
  task automatic send_number(input logic [VALUE_W-1:0] v);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    numbers_sent++;
  endtask

  // random idle cycles between beats, valid low
  task automatic idle_gap();
    if ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
  endtask

  // stop sending until every expected character has come out
  task automatic drain_output();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (chars_pending != 0);
  endtask

  task automatic run_phase(input int count, input int idle, input int stall);
    send_idle  = idle;
    recv_stall = stall;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain_output();  // pause mid phase
      send_number(random_value());
      idle_gap();
    end
    drain_output();
  endtask

  // directed corner values: zero, one digit, digit count edges, extremes
  logic [VALUE_W-1:0] corner_values [] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
    32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd1000000000,
    -32'sd1, 32'd5, -32'sd7, 32'hAAAA_AAAA, 32'h5555_5555
  };

  initial begin
    hold_req     = 0;
    send_idle    = 0;
    recv_stall   = 0;
    numbers_sent = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, full speed
    foreach (corner_values[i]) send_number(corner_values[i]);
    drain_output();

    // random part across pacing phases
    run_phase(60, 0, 0);
    run_phase(60, 76, 0);
    run_phase(60, 0, 76);
    run_phase(60, 30, 30);

    // output held off long while input keeps coming, so the block backs up
    send_idle  = 0;
    recv_stall = 0;
    hold_req++;
    repeat (25) send_number(random_value());
    drain_output();

    // tail: let any stray beat show up
    repeat (100) @(posedge clk);
    $display("%0d numbers sent over five pacing phases and a long output hold-off",
             numbers_sent);
    $display("%0d characters compared, %0d errors", chars_checked, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
